### design/pmdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdi_pkg
// Shared widths, codes and types of the periodic minimum-distance insert block.
// ----------------------------------------------------------------------------
package pmdi_pkg;
   localparam int DEPTH     = 1024;
   localparam int ADDR_W    = 10;
   localparam int CNT_W     = 11;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 3 * FRAC_BITS;
   localparam int VEC_W     = 63;
   localparam int COMP_W    = 21;
   localparam int ACC_W     = 38;
   localparam int MAG_W     = 22;
   localparam int SQ_W      = 46;
   localparam int MD_W      = 16;
   localparam int LIM_W     = 32;
   localparam int CSR_AW    = 6;
   localparam int CSR_DW    = 64;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_TEST  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_ACCEPT = 3'd1;
   localparam logic [2:0] ST_CLOSE  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_TARGET = 3'd4;

   localparam logic [2:0] REG_VEC_A  = 3'd0;
   localparam logic [2:0] REG_VEC_B  = 3'd1;
   localparam logic [2:0] REG_VEC_C  = 3'd2;
   localparam logic [2:0] REG_MIN_D  = 3'd3;
   localparam logic [2:0] REG_TARGET = 3'd4;

   typedef struct packed {
      logic done;
      logic close;
   } dist_ctl_type;
endpackage

### design/pmdi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmdi_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### design/pmdi_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdi_dist
// Bit-serial minimum-image distance test: lattice mapping by a Horner
// multiply-accumulate over the difference bits, then a serial sum of squares.
// ----------------------------------------------------------------------------
module pmdi_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pmdi_pkg::POS_W-1:0]    cand,
   input  logic [pmdi_pkg::POS_W-1:0]    stored,
   input  logic [pmdi_pkg::VEC_W-1:0]    vec_a,
   input  logic [pmdi_pkg::VEC_W-1:0]    vec_b,
   input  logic [pmdi_pkg::VEC_W-1:0]    vec_c,
   input  logic [pmdi_pkg::LIM_W-1:0]    lim,
   output pmdi_pkg::dist_ctl_type        ctl
);
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MAC  = 2'd1;
   localparam logic [1:0] PH_ABS  = 2'd2;
   localparam logic [1:0] PH_SQ   = 2'd3;
   localparam int F = pmdi_pkg::FRAC_BITS;
   localparam int C = pmdi_pkg::COMP_W;
   localparam int A = pmdi_pkg::ACC_W;
   localparam int M = pmdi_pkg::MAG_W;
   localparam int S = pmdi_pkg::SQ_W;

   logic [1:0]   phase_ff, phase_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [F-1:0] d_ff [3];
   logic [F-1:0] d_in [3];
   logic [A-1:0] acc_ff [3];
   logic [A-1:0] acc_in [3];
   logic [M-1:0] m_ff [3];
   logic [M-1:0] m_in [3];
   logic [M-1:0] msr_ff [3];
   logic [M-1:0] msr_in [3];
   logic [S-1:0] sq_ff, sq_in;
   logic         done_ff, done_in, close_ff, close_in;
   logic [A-1:0] term [3];
   logic [A-1:0] absv [3];
   logic [S-1:0] sq_add;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term[k] = (d_ff[0][F-1] ? {{(A-C){vec_a[C*k+C-1]}}, vec_a[C*k +: C]} : '0)
                 + (d_ff[1][F-1] ? {{(A-C){vec_b[C*k+C-1]}}, vec_b[C*k +: C]} : '0)
                 + (d_ff[2][F-1] ? {{(A-C){vec_c[C*k+C-1]}}, vec_c[C*k +: C]} : '0);
         absv[k] = acc_ff[k][A-1] ? (~acc_ff[k] + 1'b1) : acc_ff[k];
      end
      sq_add = (msr_ff[0][M-1] ? {{(S-M){1'b0}}, m_ff[0]} : '0)
             + (msr_ff[1][M-1] ? {{(S-M){1'b0}}, m_ff[1]} : '0)
             + (msr_ff[2][M-1] ? {{(S-M){1'b0}}, m_ff[2]} : '0);

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      m_in     = m_ff;
      msr_in   = msr_ff;
      sq_in    = sq_ff;
      done_in  = 1'b0;
      close_in = close_ff;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               for (int k = 0; k < 3; k++) begin
                  d_in[k]   = cand[F*k +: F] - stored[F*k +: F];
                  acc_in[k] = '0;
               end
               cnt_in   = '0;
               phase_in = PH_MAC;
            end
         end
         PH_MAC: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = (cnt_ff == 5'd0) ? (A'(0) - term[k])
                                            : ({acc_ff[k][A-2:0], 1'b0} + term[k]);
               d_in[k]   = {d_ff[k][F-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(F - 1)) begin
               phase_in = PH_ABS;
            end
         end
         PH_ABS: begin
            for (int k = 0; k < 3; k++) begin
               m_in[k]   = absv[k][F +: M];
               msr_in[k] = absv[k][F +: M];
            end
            sq_in    = '0;
            cnt_in   = '0;
            phase_in = PH_SQ;
         end
         PH_SQ: begin
            sq_in = {sq_ff[S-2:0], 1'b0} + sq_add;
            for (int k = 0; k < 3; k++) begin
               msr_in[k] = {msr_ff[k][M-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(M - 1)) begin
               done_in  = 1'b1;
               close_in = sq_in < {{(S-pmdi_pkg::LIM_W){1'b0}}, lim};
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      d_ff     <= d_in;
      acc_ff   <= acc_in;
      m_ff     <= m_in;
      msr_ff   <= msr_in;
      sq_ff    <= sq_in;
      close_ff <= close_in;
   end

   assign ctl.done  = done_ff;
   assign ctl.close = close_ff;
endmodule

### design/periodic_min_distance_insert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_min_distance_insert_top
// Atom table with minimum-image overlap check of candidate insertions.
// Load, clear and refused items pass from accept straight to the result register.
// A candidate walks the stored atoms up to the first close one, each with one RAM read,
// a serial lattice MAC over the difference bits and a serial sum of squares.
// One item at a time; the next is taken once the result is registered.
// Synchronous reset empties the table counts and loads register reset values.
// ----------------------------------------------------------------------------
module periodic_min_distance_insert_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // frac_x, frac_y, frac_z
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // conflict_index, stored_count, accepted_count
   output logic [2:0]  rsp_tuser,  // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;
   localparam int AW = pmdi_pkg::ADDR_W;
   localparam int CW = pmdi_pkg::CNT_W;

   logic [2:0]  state_ff, state_in;
   logic [62:0] vec_a_ff, vec_b_ff, vec_c_ff;
   logic [15:0] min_d_ff;
   logic [10:0] target_ff;
   logic [31:0] lim_ff;
   logic [CW-1:0] count_ff, count_in, new_ff, new_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [47:0] cand_ff, cand_in;
   logic [2:0]  status_ff, status_in;
   logic [AW-1:0] conf_ff, conf_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;
   logic        we, start, full, cfg_wr;
   logic [47:0] wdata, rdata;
   pmdi_pkg::dist_ctl_type dctl;

   assign full   = count_ff[CW-1];
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;

   pmdi_ram #(.WIDTH(pmdi_pkg::POS_W), .DEPTH(pmdi_pkg::DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[AW-1:0]),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   pmdi_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cand   (cand_ff),
      .stored (rdata),
      .vec_a  (vec_a_ff),
      .vec_b  (vec_b_ff),
      .vec_c  (vec_c_ff),
      .lim    (lim_ff),
      .ctl    (dctl)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      new_in    = new_ff;
      idx_in    = idx_ff;
      cand_in   = cand_ff;
      status_in = status_ff;
      conf_in   = conf_ff;
      we        = 1'b0;
      start     = 1'b0;
      wdata     = cand_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               status_in = pmdi_pkg::ST_OK;
               conf_in   = '0;
               cand_in   = req_tdata;
               wdata     = req_tdata;
               state_in  = S_DONE;
               unique case (req_tuser)
                  pmdi_pkg::FUNC_LOAD: begin
                     if (full) begin
                        status_in = pmdi_pkg::ST_FULL;
                     end else begin
                        we       = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pmdi_pkg::FUNC_TEST: begin
                     if (new_ff >= target_ff) begin
                        status_in = pmdi_pkg::ST_TARGET;
                     end else if (full) begin
                        status_in = pmdi_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        status_in = pmdi_pkg::ST_ACCEPT;
                        we        = 1'b1;
                        count_in  = count_ff + 1'b1;
                        new_in    = new_ff + 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  pmdi_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     new_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_READ:  state_in = S_START;
         S_START: begin
            start    = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (dctl.done) begin
               if (dctl.close) begin
                  status_in = pmdi_pkg::ST_CLOSE;
                  conf_in   = idx_ff;
                  state_in  = S_DONE;
               end else if ({1'b0, idx_ff} + 1'b1 == count_ff) begin
                  status_in = pmdi_pkg::ST_ACCEPT;
                  we        = 1'b1;
                  count_in  = count_ff + 1'b1;
                  new_in    = new_ff + 1'b1;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         new_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vec_a_ff     <= '0;
         vec_b_ff     <= '0;
         vec_c_ff     <= '0;
         min_d_ff     <= 16'd1024;
         target_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         new_ff   <= new_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_wr) begin
            unique case (csr_paddr[5:3])
               pmdi_pkg::REG_VEC_A:  vec_a_ff  <= csr_pwdata[62:0];
               pmdi_pkg::REG_VEC_B:  vec_b_ff  <= csr_pwdata[62:0];
               pmdi_pkg::REG_VEC_C:  vec_c_ff  <= csr_pwdata[62:0];
               pmdi_pkg::REG_MIN_D:  min_d_ff  <= csr_pwdata[15:0];
               pmdi_pkg::REG_TARGET: target_ff <= csr_pwdata[10:0];
               default: ;
            endcase
         end
      end
      idx_ff    <= idx_in;
      cand_ff   <= cand_in;
      status_ff <= status_in;
      conf_ff   <= conf_in;
      lim_ff    <= min_d_ff * min_d_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {new_ff, count_ff, conf_ff};
         rsp_user_ff <= status_ff;
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         pmdi_pkg::REG_VEC_A:  csr_prdata = {1'b0, vec_a_ff};
         pmdi_pkg::REG_VEC_B:  csr_prdata = {1'b0, vec_b_ff};
         pmdi_pkg::REG_VEC_C:  csr_prdata = {1'b0, vec_c_ff};
         pmdi_pkg::REG_MIN_D:  csr_prdata = {48'd0, min_d_ff};
         pmdi_pkg::REG_TARGET: csr_prdata = {53'd0, target_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

### design/pmdi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdi_checker
// Port-level checks of the periodic minimum-distance insert block.
// ----------------------------------------------------------------------------
module pmdi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != pmdi_pkg::ST_CLOSE |-> rsp_tdata[9:0] == 10'd0)
      else $error("conflict index set without conflict");

   a_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == pmdi_pkg::ST_ACCEPT
      |-> rsp_tdata[31:21] != 11'd0 && rsp_tdata[20:10] >= rsp_tdata[31:21])
      else $error("accepted count inconsistent");
endmodule

bind periodic_min_distance_insert_top pmdi_checker u_pmdi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
